// ----- rtl/core/vtpc_pkg.sv -----
package vtpc_pkg;

    localparam int TABLE_WORDS = 15;
    localparam int ROWS        = 3;
    localparam int ORIGIN_BASE = 12;
    localparam int FRAC_BITS   = 14;
    localparam int SUM_W       = 32 + FRAC_BITS;
    localparam int DIV_W       = 62;
    localparam int DIV_STAGES  = DIV_W;
    localparam int REM_W       = 31;
    localparam int PADDR_W     = 5;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_VERTEX = 1'b1;

    localparam logic [2:0] REG_LENS       = 3'd0;
    localparam logic [2:0] REG_HALF_W     = 3'd1;
    localparam logic [2:0] REG_HALF_H     = 3'd2;
    localparam logic [2:0] REG_WINDOW_W   = 3'd3;
    localparam logic [2:0] REG_WINDOW_H   = 3'd4;
    localparam logic [2:0] REG_FADE       = 3'd5;
    localparam logic [2:0] REG_NEAR       = 3'd6;
    localparam logic [2:0] REG_SPLIT      = 3'd7;

    localparam logic signed [32:0] NEAR_Z  = 33'sd32;
    localparam logic signed [32:0] CULL_Z  = 33'sd256;
    localparam logic [32:0]        CULL_XY = 33'd768;

    localparam logic [15:0] FLAG_NEAR   = 16'h0001;
    localparam logic [15:0] FLAG_SPLIT  = 16'h0002;
    localparam logic [15:0] FLAG_LEFT   = 16'h0008;
    localparam logic [15:0] FLAG_RIGHT  = 16'h0010;
    localparam logic [15:0] FLAG_TOP    = 16'h0020;
    localparam logic [15:0] FLAG_BOTTOM = 16'h0040;
    localparam logic [15:0] FLAG_FADE   = 16'h0080;
    localparam logic [15:0] FLAG_BEHIND = 16'h0100;
    localparam logic [15:0] FLAG_ALWAYS = 16'h0400;
    localparam logic [15:0] FLAG_CULL   = 16'hFFFF;

    typedef struct packed {
        logic [31:0] tx;
        logic [31:0] ty;
        logic [31:0] tz;
        logic [31:0] reach;
        logic [15:0] flags;
        logic        cull;
        logic        near;
        logic        circ;
        logic        negx;
        logic        negy;
    } t_side;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DIV_W-1:0] dq;
    } t_div_lane;

    // One restoring division step: the next dividend bit shifts into the
    // remainder and the quotient bit shifts into the freed low end.
    function automatic t_div_lane div_step(t_div_lane l, logic [REM_W-1:0] d);
        logic [REM_W:0] sh;
        logic           ge;
        logic [REM_W:0] diff;
        t_div_lane      r;
        sh   = {l.rem, l.dq[DIV_W-1]};
        ge   = (sh >= {1'b0, d});
        diff = sh - {1'b0, d};
        r.rem = ge ? diff[REM_W-1:0] : sh[REM_W-1:0];
        r.dq  = {l.dq[DIV_W-2:0], ge};
        return r;
    endfunction

endpackage

// ----- rtl/core/vertex_transform_perspective_clip_top.sv -----
// Fixed-point vertex transform, perspective projection and clip flagging.
// The input channel (i_valid/o_ready) carries one item per handshake. A load
// item (func 0) writes one word of the 15-word transform table; it yields no
// result. A vertex item (func 1) is rotated, offset by the origin, projected
// and flagged, and yields exactly one result item on o_valid/i_ready.
// The APB port holds the lens, screen center, window and depth thresholds;
// the user must write it only while no item is in flight, which the block
// does not enforce, and pready is always high. The datapath is a 71-stage
// pipeline: six stages of rotation, origin add, lens scaling and dividend
// setup, 62 stages of a one-bit-per-stage restoring divider (a 62-bit
// dividend over the view depth), and three stages of final scaling, screen
// offset and clip flagging. One item can be accepted on every cycle while
// the receiver does not stall, and the divider makes up most of the depth.
// When the receiver stalls, the whole pipeline holds and o_ready drops, so
// no item is lost or repeated; bubbles drain as soon as the output is free.
// Reset clears the table, the registers and all stage valid bits.
module vertex_transform_perspective_clip_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_func,
    input  logic [3:0]                      i_table_index,
    input  logic signed [31:0]              i_table_value,
    input  logic signed [23:0]              i_coord_x,
    input  logic signed [23:0]              i_coord_y,
    input  logic signed [23:0]              i_coord_z,
    input  logic                            i_projection_mode,
    input  logic [15:0]                     i_flags_in,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [31:0]              o_screen_x,
    output logic signed [31:0]              o_screen_y,
    output logic signed [31:0]              o_view_depth,
    output logic signed [31:0]              o_view_range,
    output logic [15:0]                     o_clip_mask,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [vtpc_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    // Configuration registers.
    logic [14:0] r_lens;
    logic [11:0] r_half_w;
    logic [11:0] r_half_h;
    logic [12:0] r_win_w;
    logic [12:0] r_win_h;
    logic [23:0] r_fade;
    logic [23:0] r_near;
    logic [23:0] r_split;
    logic [2:0]  w_reg_idx;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lens   <= '0;
            r_half_w <= '0;
            r_half_h <= '0;
            r_win_w  <= '0;
            r_win_h  <= '0;
            r_fade   <= '0;
            r_near   <= '0;
            r_split  <= '0;
        end else if (psel && penable && pwrite) begin
            case (w_reg_idx)
                vtpc_pkg::REG_LENS:     r_lens   <= pwdata[14:0];
                vtpc_pkg::REG_HALF_W:   r_half_w <= pwdata[11:0];
                vtpc_pkg::REG_HALF_H:   r_half_h <= pwdata[11:0];
                vtpc_pkg::REG_WINDOW_W: r_win_w  <= pwdata[12:0];
                vtpc_pkg::REG_WINDOW_H: r_win_h  <= pwdata[12:0];
                vtpc_pkg::REG_FADE:     r_fade   <= pwdata[23:0];
                vtpc_pkg::REG_NEAR:     r_near   <= pwdata[23:0];
                vtpc_pkg::REG_SPLIT:    r_split  <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            vtpc_pkg::REG_LENS:     prdata = {17'd0, r_lens};
            vtpc_pkg::REG_HALF_W:   prdata = {20'd0, r_half_w};
            vtpc_pkg::REG_HALF_H:   prdata = {20'd0, r_half_h};
            vtpc_pkg::REG_WINDOW_W: prdata = {19'd0, r_win_w};
            vtpc_pkg::REG_WINDOW_H: prdata = {19'd0, r_win_h};
            vtpc_pkg::REG_FADE:     prdata = {8'd0, r_fade};
            vtpc_pkg::REG_NEAR:     prdata = {8'd0, r_near};
            vtpc_pkg::REG_SPLIT:    prdata = {8'd0, r_split};
            default:                prdata = '0;
        endcase
    end

    // The whole pipeline advances together; it holds only while a result
    // sits in the output register and the receiver is not taking it.
    logic r_o_valid;
    logic w_en;
    assign w_en    = !r_o_valid || i_ready;
    assign o_ready = w_en;

    // Stage 0: input register.
    logic               r_s0_valid;
    logic               r_s0_func;
    logic [3:0]         r_s0_idx;
    logic [31:0]        r_s0_value;
    logic signed [23:0] r_s0_x;
    logic signed [23:0] r_s0_y;
    logic signed [23:0] r_s0_z;
    logic               r_s0_mode;
    logic [15:0]        r_s0_flags;

    // Transform table. Loads are committed as they leave stage 0, the same
    // point where vertices read the table, so item order is kept.
    logic [31:0] r_table [vtpc_pkg::TABLE_WORDS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < vtpc_pkg::TABLE_WORDS; k++) begin
                r_table[k] <= '0;
            end
        end else if (w_en && r_s0_valid && (r_s0_func == vtpc_pkg::FUNC_LOAD)
                     && (r_s0_idx < 4'(vtpc_pkg::TABLE_WORDS))) begin
            r_table[r_s0_idx] <= r_s0_value;
        end
    end

    // Stage 1: the three products of each row.
    logic [vtpc_pkg::SUM_W-1:0] r_s1_p1  [vtpc_pkg::ROWS];
    logic [vtpc_pkg::SUM_W-1:0] r_s1_p2  [vtpc_pkg::ROWS];
    logic [31:0]                r_s1_d   [vtpc_pkg::ROWS];
    logic [31:0]                r_s1_org [vtpc_pkg::ROWS];
    logic [vtpc_pkg::SUM_W-1:0] r_s1_xy;
    logic                       r_s1_valid;
    logic                       r_s1_mode;
    logic [15:0]                r_s1_flags;

    logic signed [32:0] w_ya  [vtpc_pkg::ROWS];
    logic signed [32:0] w_xb  [vtpc_pkg::ROWS];
    logic signed [65:0] w_pp2 [vtpc_pkg::ROWS];
    logic signed [55:0] w_pp1 [vtpc_pkg::ROWS];
    logic signed [47:0] w_pxy;

    always_comb begin
        for (int r = 0; r < vtpc_pkg::ROWS; r++) begin
            w_ya[r]  = 33'(r_s0_y) + 33'($signed(r_table[r*4]));
            w_xb[r]  = 33'(r_s0_x) + 33'($signed(r_table[r*4+1]));
            w_pp2[r] = 66'(w_ya[r]) * 66'(w_xb[r]);
            w_pp1[r] = 56'(r_s0_z) * 56'($signed(r_table[r*4+2]));
        end
        w_pxy = 48'(r_s0_x) * 48'(r_s0_y);
    end

    // Stage 2: row sums modulo 2^46.
    logic [vtpc_pkg::SUM_W-1:0] r_s2_sum [vtpc_pkg::ROWS];
    logic [31:0]                r_s2_org [vtpc_pkg::ROWS];
    logic                       r_s2_valid;
    logic                       r_s2_mode;
    logic [15:0]                r_s2_flags;

    // Stage 3: fraction dropped, origin added.
    logic [31:0] r_s3_t [vtpc_pkg::ROWS];
    logic        r_s3_valid;
    logic        r_s3_mode;
    logic [15:0] r_s3_flags;

    // Stage 4: depth tests, render distance and lens products.
    vtpc_pkg::t_side    r_s4_side;
    logic               r_s4_valid;
    logic signed [46:0] r_s4_mx;
    logic signed [46:0] r_s4_my;

    logic [31:0]        w_tx;
    logic [31:0]        w_ty;
    logic [31:0]        w_tz;
    logic signed [32:0] w_tz_s;
    logic [31:0]        w_magx;
    logic [31:0]        w_magy;
    logic               w_fade;
    logic               w_near;
    logic               w_below_near;
    logic               w_below_split;
    logic [15:0]        w_flags4;
    vtpc_pkg::t_side    w_side4;

    always_comb begin
        w_tx   = r_s3_t[0];
        w_ty   = r_s3_t[1];
        w_tz   = r_s3_t[2];
        w_tz_s = $signed({w_tz[31], w_tz});
        w_magx = w_tx[31] ? (32'd0 - w_tx) : w_tx;
        w_magy = w_ty[31] ? (32'd0 - w_ty) : w_ty;
        w_fade        = w_tz_s > $signed({9'd0, r_fade});
        w_near        = w_tz_s < vtpc_pkg::NEAR_Z;
        w_below_near  = w_tz_s < $signed({9'd0, r_near});
        w_below_split = w_tz_s < $signed({9'd0, r_split});
        w_flags4 = r_s3_flags | vtpc_pkg::FLAG_ALWAYS;
        if (w_fade) begin
            w_flags4 = w_flags4 | vtpc_pkg::FLAG_FADE;
        end
        if (w_near) begin
            w_flags4 = w_flags4 | vtpc_pkg::FLAG_BEHIND | vtpc_pkg::FLAG_NEAR
                     | vtpc_pkg::FLAG_SPLIT;
        end else if (w_below_near) begin
            w_flags4 = w_flags4 | vtpc_pkg::FLAG_NEAR;
            if (w_below_split) begin
                w_flags4 = w_flags4 | vtpc_pkg::FLAG_SPLIT;
            end
        end
        w_side4.tx    = w_tx;
        w_side4.ty    = w_ty;
        w_side4.tz    = w_tz;
        w_side4.reach = r_s3_mode ? (w_magx + w_magy + w_tz) : w_tz;
        w_side4.flags = w_flags4;
        w_side4.cull  = (w_tz_s < vtpc_pkg::CULL_Z)
                      && (({1'b0, w_magx} + {1'b0, w_magy}) >= vtpc_pkg::CULL_XY);
        w_side4.near  = w_near;
        w_side4.circ  = r_s3_mode;
        w_side4.negx  = 1'b0;
        w_side4.negy  = 1'b0;
    end

    // Divider pipeline: entry 0 holds the prepared dividends, each further
    // entry resolves one quotient bit.
    logic                 r_dv_valid [vtpc_pkg::DIV_STAGES+1];
    vtpc_pkg::t_side      r_dv_side  [vtpc_pkg::DIV_STAGES+1];
    vtpc_pkg::t_div_lane  r_dv_x     [vtpc_pkg::DIV_STAGES+1];
    vtpc_pkg::t_div_lane  r_dv_y     [vtpc_pkg::DIV_STAGES+1];

    logic [46:0]          w_absx;
    logic [46:0]          w_absy;
    vtpc_pkg::t_side      w_side5;
    vtpc_pkg::t_div_lane  w_lane_x;
    vtpc_pkg::t_div_lane  w_lane_y;

    always_comb begin
        w_absx = r_s4_mx[46] ? (47'd0 - r_s4_mx) : r_s4_mx;
        w_absy = r_s4_my[46] ? (47'd0 - r_s4_my) : r_s4_my;
        w_side5      = r_s4_side;
        w_side5.negx = r_s4_mx[46];
        w_side5.negy = r_s4_my[46];
        w_lane_x.rem = '0;
        w_lane_y.rem = '0;
        // In circular mode the x lane forms the lens-over-depth factor.
        w_lane_x.dq  = r_s4_side.circ ? {31'd0, r_lens, 16'd0} : {w_absx[45:0], 16'd0};
        w_lane_y.dq  = {w_absy[45:0], 16'd0};
    end

    // Post-divide stage 1: signed quotient or coordinate times factor.
    logic               r_p1_valid;
    vtpc_pkg::t_side    r_p1_side;
    logic [47:0]        r_p1_qx;
    logic [47:0]        r_p1_qy;
    logic [47:0]        r_p1_cx;
    logic [47:0]        r_p1_cy;

    vtpc_pkg::t_side    w_side_d;
    logic [47:0]        w_qx;
    logic [47:0]        w_qy;
    logic signed [63:0] w_cx;
    logic signed [63:0] w_cy;
    logic signed [63:0] w_k;

    always_comb begin
        w_side_d = r_dv_side[vtpc_pkg::DIV_STAGES];
        w_qx = r_dv_x[vtpc_pkg::DIV_STAGES].dq[47:0];
        w_qy = r_dv_y[vtpc_pkg::DIV_STAGES].dq[47:0];
        w_k  = $signed({33'd0, r_dv_x[vtpc_pkg::DIV_STAGES].dq[30:0]});
        w_cx = 64'($signed(w_side_d.tx)) * w_k;
        w_cy = 64'($signed(w_side_d.ty)) * w_k;
    end

    // Post-divide stage 2: screen offset.
    logic               r_p2_valid;
    vtpc_pkg::t_side    r_p2_side;
    logic [31:0]        r_p2_sx;
    logic [31:0]        r_p2_sy;

    logic [31:0]        w_px;
    logic [31:0]        w_py;

    always_comb begin
        if (r_p1_side.near) begin
            w_px = r_p1_side.circ ? {r_p1_side.tx[28:0], 3'd0} : r_p1_side.tx;
            w_py = r_p1_side.circ ? {r_p1_side.ty[28:0], 3'd0} : r_p1_side.ty;
        end else if (r_p1_side.circ) begin
            w_px = r_p1_cx[47:16];
            w_py = r_p1_cy[47:16];
        end else begin
            w_px = r_p1_qx[47:16];
            w_py = r_p1_qy[47:16];
        end
    end

    // Output stage: edge flags and the near-and-wide override.
    logic [31:0] r_o_sx;
    logic [31:0] r_o_sy;
    logic [31:0] r_o_depth;
    logic [31:0] r_o_reach;
    logic [15:0] r_o_flags;
    logic [15:0] w_flags_o;

    always_comb begin
        w_flags_o = r_p2_side.flags;
        if (r_p2_sx[31]) begin
            w_flags_o = w_flags_o | vtpc_pkg::FLAG_LEFT;
        end else if (r_p2_sx >= {19'd0, r_win_w}) begin
            w_flags_o = w_flags_o | vtpc_pkg::FLAG_RIGHT;
        end
        if (r_p2_sy[31]) begin
            w_flags_o = w_flags_o | vtpc_pkg::FLAG_TOP;
        end else if (r_p2_sy >= {19'd0, r_win_h}) begin
            w_flags_o = w_flags_o | vtpc_pkg::FLAG_BOTTOM;
        end
        if (r_p2_side.cull) begin
            w_flags_o = vtpc_pkg::FLAG_CULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            for (int k = 0; k <= vtpc_pkg::DIV_STAGES; k++) begin
                r_dv_valid[k] <= 1'b0;
            end
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= i_valid;
            r_s0_func  <= i_func;
            r_s0_idx   <= i_table_index;
            r_s0_value <= i_table_value;
            r_s0_x     <= i_coord_x;
            r_s0_y     <= i_coord_y;
            r_s0_z     <= i_coord_z;
            r_s0_mode  <= i_projection_mode;
            r_s0_flags <= i_flags_in;

            r_s1_valid <= r_s0_valid && (r_s0_func == vtpc_pkg::FUNC_VERTEX);
            for (int r = 0; r < vtpc_pkg::ROWS; r++) begin
                r_s1_p1[r]  <= w_pp1[r][vtpc_pkg::SUM_W-1:0];
                r_s1_p2[r]  <= w_pp2[r][vtpc_pkg::SUM_W-1:0];
                r_s1_d[r]   <= r_table[r*4+3];
                r_s1_org[r] <= r_table[vtpc_pkg::ORIGIN_BASE+r];
            end
            r_s1_xy    <= w_pxy[vtpc_pkg::SUM_W-1:0];
            r_s1_mode  <= r_s0_mode;
            r_s1_flags <= r_s0_flags;

            r_s2_valid <= r_s1_valid;
            for (int r = 0; r < vtpc_pkg::ROWS; r++) begin
                r_s2_sum[r] <= r_s1_p1[r] + r_s1_p2[r]
                             - {{(vtpc_pkg::SUM_W-32){r_s1_d[r][31]}}, r_s1_d[r]}
                             - r_s1_xy;
                r_s2_org[r] <= r_s1_org[r];
            end
            r_s2_mode  <= r_s1_mode;
            r_s2_flags <= r_s1_flags;

            r_s3_valid <= r_s2_valid;
            for (int r = 0; r < vtpc_pkg::ROWS; r++) begin
                r_s3_t[r] <= r_s2_sum[r][vtpc_pkg::SUM_W-1:vtpc_pkg::FRAC_BITS]
                           + r_s2_org[r];
            end
            r_s3_mode  <= r_s2_mode;
            r_s3_flags <= r_s2_flags;

            r_s4_valid <= r_s3_valid;
            r_s4_side  <= w_side4;
            r_s4_mx    <= 47'($signed(w_tx)) * 47'($signed({1'b0, r_lens}));
            r_s4_my    <= 47'($signed(w_ty)) * 47'($signed({1'b0, r_lens}));

            r_dv_valid[0] <= r_s4_valid;
            r_dv_side[0]  <= w_side5;
            r_dv_x[0]     <= w_lane_x;
            r_dv_y[0]     <= w_lane_y;
            for (int k = 1; k <= vtpc_pkg::DIV_STAGES; k++) begin
                r_dv_valid[k] <= r_dv_valid[k-1];
                r_dv_side[k]  <= r_dv_side[k-1];
                r_dv_x[k]     <= vtpc_pkg::div_step(r_dv_x[k-1],
                                                    r_dv_side[k-1].tz[30:0]);
                r_dv_y[k]     <= vtpc_pkg::div_step(r_dv_y[k-1],
                                                    r_dv_side[k-1].tz[30:0]);
            end

            r_p1_valid <= r_dv_valid[vtpc_pkg::DIV_STAGES];
            r_p1_side  <= w_side_d;
            r_p1_qx    <= w_side_d.negx ? (48'd0 - w_qx) : w_qx;
            r_p1_qy    <= w_side_d.negy ? (48'd0 - w_qy) : w_qy;
            r_p1_cx    <= w_cx[47:0];
            r_p1_cy    <= w_cy[47:0];

            r_p2_valid <= r_p1_valid;
            r_p2_side  <= r_p1_side;
            r_p2_sx    <= {20'd0, r_half_w} + w_px;
            r_p2_sy    <= {20'd0, r_half_h} - w_py;

            r_o_valid  <= r_p2_valid;
            r_o_sx     <= r_p2_sx;
            r_o_sy     <= r_p2_sy;
            r_o_depth  <= r_p2_side.tz;
            r_o_reach  <= r_p2_side.reach;
            r_o_flags  <= w_flags_o;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_screen_x   = $signed(r_o_sx);
    assign o_screen_y   = $signed(r_o_sy);
    assign o_view_depth = $signed(r_o_depth);
    assign o_view_range = $signed(r_o_reach);
    assign o_clip_mask  = r_o_flags;

endmodule
